>>> hdl/nrle_pkg.sv
// shared types and constants of the nibble run-length decoder
package nrle_pkg;

	localparam int CW             = 10;
	localparam int RW             = CW + 1;
	localparam int COORD_BITS_DEF = 10;
	localparam int MIN_WIDTH      = 4;
	localparam int WIDTH_RESET    = 720;
	localparam int HEIGHT_RESET   = 576;
	localparam int NIB_W          = 4;
	localparam int COLOR_W        = 2;

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CW-1:0]      row;
		logic [CW-1:0]      start;
		logic [CW-1:0]      len;
		logic [COLOR_W-1:0] color;
	} run_t;

	typedef struct packed {
		run_t [2:0] runs;
		logic [1:0] n;
		logic       done;
		logic       shortd;
	} rec_t;

endpackage

>>> hdl/nrle_front.sv
// front end: takes bytes, decodes one nibble per cycle unless the queue stalls it, builds a per-byte run record
module nrle_front import nrle_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          final_byte,
	input  logic          new_image,
	input  logic [CW-1:0] image_width,
	input  logic [CW-1:0] image_height,
	output logic          q_valid,
	input  logic          q_ready,
	output rec_t          q_data
);

	localparam int OB = (COORD_BITS < CW) ? COORD_BITS : CW;
	localparam logic [CW-1:0] CMASK = CW'((1 << OB) - 1);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_HI   = 3'b010,
		F_LO   = 3'b100
	} fstate_t;

	typedef struct packed {
		logic [RW-1:0] row;
		logic          odd;
		logic          comp;
	} rows_t;

	fstate_t       state_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          odd_q;
	logic          await_q;
	logic          comp_q;
	logic [7:0]    byte_q;
	logic          fin_q;
	logic          wasc_q;
	logic          stop_q;
	logic [1:0]    cnt_q;
	run_t [1:0]    runs_q;

	logic [CW-1:0]      w;
	logic [CW-1:0]      h;
	logic [NIB_W-1:0]   nib;
	logic               active;
	logic [RW-1:0]      s_row;
	logic [CW-1:0]      s_col;
	logic               s_odd;
	logic               s_await;
	logic               s_comp;
	logic               s_stop;
	logic [1:0]         s_ne;
	run_t               s_e0;
	run_t               s_e1;
	rows_t              chk;
	logic [CW-1:0]      cnt;
	logic [CW-1:0]      room;
	logic [CW-1:0]      len;
	logic [1:0]         rem;
	logic [COLOR_W-1:0] color;

	logic [1:0] total;
	logic       done;
	logic       shortd;
	logic       push_need;
	logic       lo_go;
	logic       accept;
	logic       comp_now;

	function automatic rows_t check_rows(input logic [RW-1:0] r, input logic o,
			input logic cp, input logic [CW-1:0] hh);
		rows_t res;
		res.row  = r;
		res.odd  = o;
		res.comp = cp;
		if (!cp && r >= RW'(hh)) begin
			if (!o) begin
				res.odd  = 1'b1;
				res.row  = RW'(1);
				res.comp = (hh == CW'(1));
			end else begin
				res.comp = 1'b1;
			end
		end
		return res;
	endfunction

	assign w   = (image_width < CW'(MIN_WIDTH)) ? CW'(MIN_WIDTH) : image_width;
	assign h   = (image_height == '0) ? CW'(1) : image_height;
	assign nib = (state_q == F_HI) ? byte_q[7:4] : byte_q[3:0];
	assign active = !comp_q && ((state_q == F_HI) || (state_q == F_LO && !stop_q));

	// one nibble of decoding
	always_comb begin
		s_row   = row_q;
		s_col   = col_q;
		s_odd   = odd_q;
		s_await = await_q;
		s_comp  = comp_q;
		s_stop  = 1'b0;
		s_ne    = 2'd0;
		s_e0    = '0;
		s_e1    = '0;
		chk     = '0;
		cnt     = '0;
		room    = '0;
		len     = '0;
		rem     = '0;
		color   = nib[COLOR_W-1:0];
		if (active) begin
			if (s_col >= w) begin
				s_col = '0;
				s_row = s_row + RW'(2);
			end
			chk    = check_rows(s_row, s_odd, s_comp, h);
			s_row  = chk.row;
			s_odd  = chk.odd;
			s_comp = chk.comp;
			room   = w - s_col;
			if (s_comp) begin
				s_stop = 1'b1;
			end else if (s_await) begin
				s_e0    = '{row: CW'(s_row) & CMASK, start: s_col & CMASK, len: room, color: color};
				s_ne    = 2'd1;
				s_await = 1'b0;
				s_col   = '0;
				chk     = check_rows(s_row + RW'(2), s_odd, s_comp, h);
				s_row   = chk.row;
				s_odd   = chk.odd;
				s_comp  = chk.comp;
				s_stop  = 1'b1;
			end else if (nib == '0) begin
				s_await = 1'b1;
			end else begin
				cnt   = (nib[3:2] == 2'd0) ? CW'(1) : CW'(nib[3:2]);
				len   = (cnt < room) ? cnt : room;
				rem   = 2'(cnt - len);
				s_e0  = '{row: CW'(s_row) & CMASK, start: s_col & CMASK, len: len, color: color};
				s_ne  = 2'd1;
				s_col = s_col + len;
				if (s_col >= w) begin
					s_col  = '0;
					chk    = check_rows(s_row + RW'(2), s_odd, s_comp, h);
					s_row  = chk.row;
					s_odd  = chk.odd;
					s_comp = chk.comp;
					if (rem != 2'd0 && !s_comp) begin
						s_e1  = '{row: CW'(s_row) & CMASK, start: '0, len: CW'(rem), color: color};
						s_ne  = 2'd2;
						s_col = CW'(rem);
					end
					s_stop = 1'b1;
				end
			end
		end
	end

	// byte record
	always_comb begin
		total     = cnt_q + s_ne;
		done      = s_comp && !wasc_q;
		shortd    = fin_q && !s_comp;
		push_need = (total != 2'd0) || done || shortd;
		q_data.done   = done;
		q_data.shortd = shortd;
		q_data.n      = (total == 2'd0) ? 2'd1 : total;
		if (total == 2'd0) begin
			q_data.runs[0] = '0;
		end else if (cnt_q != 2'd0) begin
			q_data.runs[0] = runs_q[0];
		end else begin
			q_data.runs[0] = s_e0;
		end
		if (cnt_q == 2'd2) begin
			q_data.runs[1] = runs_q[1];
			q_data.runs[2] = s_e0;
		end else if (cnt_q == 2'd1) begin
			q_data.runs[1] = s_e0;
			q_data.runs[2] = s_e1;
		end else begin
			q_data.runs[1] = s_e1;
			q_data.runs[2] = s_e1;
		end
	end

	assign q_valid  = (state_q == F_LO) && push_need;
	assign lo_go    = (state_q == F_LO) && !(push_need && !q_ready);
	assign in_ready = (state_q == F_IDLE) || lo_go;
	assign accept   = in_valid && in_ready;
	assign comp_now = lo_go ? s_comp : comp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			odd_q   <= 1'b0;
			await_q <= 1'b0;
			comp_q  <= 1'b0;
			cnt_q   <= '0;
			stop_q  <= 1'b0;
			wasc_q  <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) state_q <= F_HI;
				end
				F_HI: begin
					state_q <= F_LO;
				end
				F_LO: begin
					if (lo_go) state_q <= accept ? F_HI : F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
			if (state_q == F_HI || lo_go) begin
				row_q   <= s_row;
				col_q   <= s_col;
				odd_q   <= s_odd;
				await_q <= s_await;
				comp_q  <= s_comp;
			end
			if (state_q == F_HI) begin
				cnt_q  <= s_ne;
				stop_q <= s_stop;
			end
			if (accept) begin
				wasc_q <= new_image ? 1'b0 : comp_now;
				if (new_image) begin
					row_q   <= '0;
					col_q   <= '0;
					odd_q   <= 1'b0;
					await_q <= 1'b0;
					comp_q  <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			fin_q  <= final_byte;
		end
		if (state_q == F_HI) begin
			runs_q[0] <= s_e0;
			runs_q[1] <= s_e1;
		end
	end

endmodule

>>> hdl/nrle_queue.sv
// two-entry queue of byte records between front and back
module nrle_queue import nrle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  rec_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output rec_t rd_data
);

	rec_t [1:0] mem_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> hdl/nrle_back.sv
// back end: sends the runs of each record one beat at a time
module nrle_back import nrle_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_valid,
	output logic          rd_ready,
	input  rec_t          rd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [CW-1:0] run_row,
	output logic [CW-1:0] run_start,
	output logic [CW-1:0] run_length,
	output logic [1:0]    run_color,
	output logic          image_done,
	output logic          short_data,
	output logic          last
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic       load;
	logic       is_last;
	run_t       cur;

	assign load     = rd_valid && (!valid_q || out_ready);
	assign is_last  = (idx_q == rd_data.n - 2'd1);
	assign rd_ready = load && is_last;
	assign cur      = rd_data.runs[idx_q];
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_row    <= cur.row;
			run_start  <= cur.start;
			run_length <= cur.len;
			run_color  <= cur.color;
			image_done <= is_last && rd_data.done;
			short_data <= is_last && rd_data.shortd;
			last       <= is_last;
		end
	end

endmodule

>>> hdl/nibble_rle_interlaced_decoder_top.sv
// top level of the interlaced nibble run-length subtitle decoder
// Each accepted byte is decoded in the front end, high nibble then low nibble, one nibble per
// cycle unless the queue stalls the low nibble. A new byte is taken only when the front end
// is idle or finishing a low nibble. A byte yields up to three runs; the front end packs them
// into one record that passes a two-entry queue to the back end, which sends one run per beat
// from its output register, so a byte with several runs holds the output for one beat per run
// while the queue lets the front end go on; width and height use the always-ready config port.
module nibble_rle_interlaced_decoder_top import nrle_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          final_byte,
	input  logic          new_image,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [CW-1:0] run_row,
	output logic [CW-1:0] run_start,
	output logic [CW-1:0] run_length,
	output logic [1:0]    run_color,
	output logic          image_done,
	output logic          short_data,
	output logic          last,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [0:0]    cfg_index,
	input  logic [CW-1:0] cfg_data
);

	logic [CW-1:0] width_q;
	logic [CW-1:0] height_q;
	logic          q_wr_valid;
	logic          q_wr_ready;
	rec_t          q_wr_data;
	logic          q_rd_valid;
	logic          q_rd_ready;
	rec_t          q_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CW'(WIDTH_RESET);
			height_q <= CW'(HEIGHT_RESET);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nrle_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.final_byte   (final_byte),
		.new_image    (new_image),
		.image_width  (width_q),
		.image_height (height_q),
		.q_valid      (q_wr_valid),
		.q_ready      (q_wr_ready),
		.q_data       (q_wr_data)
	);

	nrle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (q_wr_valid),
		.wr_ready (q_wr_ready),
		.wr_data  (q_wr_data),
		.rd_valid (q_rd_valid),
		.rd_ready (q_rd_ready),
		.rd_data  (q_rd_data)
	);

	nrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_valid   (q_rd_valid),
		.rd_ready   (q_rd_ready),
		.rd_data    (q_rd_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.run_row    (run_row),
		.run_start  (run_start),
		.run_length (run_length),
		.run_color  (run_color),
		.image_done (image_done),
		.short_data (short_data),
		.last       (last)
	);

endmodule
